// File: src/tbt_pkg.sv
package tbt_pkg;

   localparam int ADC_BITS_DEF = 10;

   // register map
   typedef enum logic [2:0] {
      REG_SUPPLY_MV     = 3'd0,
      REG_STEP_UV       = 3'd1,
      REG_SERIES_OHMS   = 3'd2,
      REG_NOMINAL_OHMS  = 3'd3,
      REG_BETA_KELVIN   = 3'd4,
      REG_NOMINAL_TEMP  = 3'd5
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [12:0] SUPPLY_MV_RST    = 13'd5000;
   localparam logic [13:0] STEP_UV_RST      = 14'd4883;
   localparam logic [15:0] SERIES_OHMS_RST  = 16'd1000;
   localparam logic [15:0] NOMINAL_OHMS_RST = 16'd1020;
   localparam logic [13:0] BETA_KELVIN_RST  = 14'd3348;
   localparam logic [14:0] NOMINAL_TEMP_RST = 15'd2500;

   // datapath widths
   localparam int SUP_W     = 23;   // supply in microvolts
   localparam int LOG_IN_W  = 39;   // resistor products
   localparam int LOG_P_W   = 6;
   localparam int LOG_F_W   = 16;
   localparam int LOG_OUT_W = LOG_P_W + LOG_F_W;
   localparam int MANT_W    = 31;
   localparam int DIV_N_W   = 54;
   localparam int DIV_D_W   = 40;
   localparam int DIV_Q_W   = 16;

   localparam int LOG_LAT = 2 + LOG_F_W;
   localparam int DIV_LAT = 1 + DIV_Q_W;

   localparam logic [29:0] LN2_Q30      = 30'd744261118;
   localparam logic [16:0] KELVIN_CENTI = 17'd27315;
   localparam logic [15:0] TK_MIN       = 16'd21815;
   localparam logic [15:0] TK_MAX       = 16'd42315;
   localparam logic [17:0] RECIP5       = 18'd209716;
   localparam logic [15:0] F_OFFSET     = 16'd3200;

   localparam logic signed [14:0] C_MIN = -15'sd5500;
   localparam logic signed [14:0] C_MAX = 15'sd15000;
   localparam logic signed [15:0] F_MIN = -16'sd6700;
   localparam logic signed [15:0] F_MAX = 16'sd30200;

endpackage

// File: src/tbt_log2.sv
module tbt_log2
   import tbt_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic [LOG_IN_W-1:0]  x,
   output logic [LOG_OUT_W-1:0] y
);

   logic [LOG_IN_W-1:0] x_ff;
   logic [LOG_P_W-1:0]  lead_in;
   logic [LOG_P_W-1:0]  lead_ff;

   logic [MANT_W-1:0]   m_ff [0:LOG_F_W];
   logic [LOG_P_W-1:0]  p_ff [0:LOG_F_W];
   logic [LOG_F_W-1:0]  f_ff [0:LOG_F_W];

   logic [2*MANT_W-1:0] sq     [0:LOG_F_W-1];
   logic [MANT_W-1:0]   m_in   [0:LOG_F_W-1];
   logic [LOG_F_W-1:0]  f_in   [0:LOG_F_W-1];
   logic [MANT_W-1:0]   norm_in;

   // leading one position
   always_comb begin
      lead_in = '0;
      for (int i = 0; i < LOG_IN_W; i++) begin
         if (x[i]) lead_in = LOG_P_W'(i);
      end
   end

   assign norm_in = MANT_W'({x_ff, {(MANT_W-1){1'b0}}} >> lead_ff);

   // one fraction bit per squaring, mantissa kept in [1,2) with 30 fraction bits
   always_comb begin
      for (int j = 0; j < LOG_F_W; j++) begin
         sq[j]   = (2*MANT_W)'(m_ff[j]) * (2*MANT_W)'(m_ff[j]);
         m_in[j] = sq[j][2*MANT_W-1] ? sq[j][2*MANT_W-1:MANT_W] : sq[j][2*MANT_W-2:MANT_W-1];
         f_in[j] = f_ff[j] | (LOG_F_W'(sq[j][2*MANT_W-1]) << (LOG_F_W-1-j));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x;
         lead_ff <= lead_in;
         m_ff[0] <= norm_in;
         p_ff[0] <= lead_ff;
         f_ff[0] <= '0;
         for (int j = 0; j < LOG_F_W; j++) begin
            m_ff[j+1] <= m_in[j];
            p_ff[j+1] <= p_ff[j];
            f_ff[j+1] <= f_in[j];
         end
      end
   end

   assign y = {p_ff[LOG_F_W], f_ff[LOG_F_W]};

endmodule

// File: src/tbt_div.sv
module tbt_div
   import tbt_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic [DIV_N_W-1:0]  num,
   input  logic [DIV_D_W-1:0]  den,
   input  logic                den_pos,
   output logic [DIV_Q_W-1:0]  quo
);

   localparam int CMP_W = DIV_D_W + DIV_Q_W;

   logic [DIV_N_W-1:0] r_ff   [0:DIV_Q_W];
   logic [DIV_D_W-1:0] d_ff   [0:DIV_Q_W];
   logic [DIV_Q_W-1:0] q_ff   [0:DIV_Q_W];
   logic               sat_ff [0:DIV_Q_W];

   logic [CMP_W-1:0]   sh   [0:DIV_Q_W-1];
   logic               ge   [0:DIV_Q_W-1];
   logic [DIV_N_W-1:0] r_in [0:DIV_Q_W-1];
   logic [DIV_Q_W-1:0] q_in [0:DIV_Q_W-1];
   logic               sat_in;

   // quotient would not fit in 16 bits, or the denominator is not positive
   assign sat_in = !den_pos || (CMP_W'(num) >= {den, {DIV_Q_W{1'b0}}});

   // restoring division, most significant quotient bit first
   always_comb begin
      for (int s = 0; s < DIV_Q_W; s++) begin
         sh[s]   = CMP_W'(d_ff[s]) << (DIV_Q_W-1-s);
         ge[s]   = CMP_W'(r_ff[s]) >= sh[s];
         r_in[s] = ge[s] ? DIV_N_W'(CMP_W'(r_ff[s]) - sh[s]) : r_ff[s];
         q_in[s] = q_ff[s] | (DIV_Q_W'(ge[s]) << (DIV_Q_W-1-s));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= num;
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         sat_ff[0] <= sat_in;
         for (int s = 0; s < DIV_Q_W; s++) begin
            r_ff[s+1]   <= r_in[s];
            d_ff[s+1]   <= d_ff[s];
            q_ff[s+1]   <= q_in[s];
            sat_ff[s+1] <= sat_ff[s];
         end
      end
   end

   assign quo = sat_ff[DIV_Q_W] ? '1 : q_ff[DIV_Q_W];

endmodule

// File: src/thermistor_beta_temperature.sv
// NTC thermistor temperature from one ADC sample of a divider midpoint, by the beta
// equation, in hundredths of a degree Celsius and Fahrenheit. The block takes one sample
// per clock while req_stall is low; most of its pipeline lies in the two log2 units (one
// squaring stage per fraction bit) and the quotient pipeline (one stage per quotient
// bit). A two-entry output (result register plus skid) lets input transfers go on while
// a result waits, and req_stall rises only once the skid entry is held. A sample of zero,
// a divider voltage at or above the supply, or a zero series, nominal or beta register
// gives fault with both temperatures zero. The user must write the registers through the
// csr port while the block is idle (not enforced); the derived constants are registered.
module thermistor_beta_temperature
   import tbt_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEF
)(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [ADC_BITS-1:0]     req_raw_code,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [14:0]      rsp_temp_c_centi,
   output logic signed [15:0]      rsp_temp_f_centi,
   output logic                    rsp_fault,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int V_W   = ADC_BITS + 14;
   localparam int CMP_W = (V_W > SUP_W) ? V_W : SUP_W;
   localparam int DEPTH = 3 + LOG_LAT + 6 + DIV_LAT + 4;
   localparam int LAST  = DEPTH - 1;

   // configuration
   logic [12:0]        supply_mv_ff;
   logic [13:0]        step_uv_ff;
   logic [15:0]        series_ohms_ff;
   logic [15:0]        nominal_ohms_ff;
   logic [13:0]        beta_kelvin_ff;
   logic signed [14:0] nominal_temp_ff;

   // derived from configuration
   logic signed [16:0] t0_ff;
   logic [36:0]        bs_ff;
   logic [29:0]        bt0_ff;
   logic [52:0]        num_ff;

   logic en;
   logic skid_v_ff;

   logic vld_ff [0:LAST];
   logic flt_ff [1:LAST];

   // front stages
   logic [V_W-1:0]         v_in, v_ff;
   logic [SUP_W-1:0]       sup_in, sup_ff;
   logic                   czero_ff;
   logic                   fault_in;
   logic [SUP_W-1:0]       diff_in, diff_ff;
   logic [SUP_W-1:0]       v23_ff;
   logic [LOG_IN_W-1:0]    rnum_ff, rden_ff;

   // log difference and denominator
   logic [LOG_OUT_W-1:0]   lnum, lden;
   logic [LOG_OUT_W-1:0]   a_in, a_ff;
   logic                   neg_ff [0:1];
   logic [51:0]            mag_ff;
   logic [51:0]            mag_rnd;
   logic signed [22:0]     lq_in, lq_ff;
   logic signed [39:0]     prod_ff;
   logic [40:0]            den_in, den_ff;
   logic [DIV_N_W-1:0]     dn_ff;
   logic [DIV_D_W-1:0]     dd_ff;
   logic                   dpos_ff;
   logic [DIV_Q_W-1:0]     tk;

   // back stages
   logic [15:0]            tkc_in;
   logic signed [14:0]     c_a_ff, c_b_ff, c_c_ff;
   logic signed [18:0]     f9_in;
   logic [17:0]            x_in, x_ff;
   logic                   fneg_b_ff, fneg_c_ff;
   logic [35:0]            qp_in;
   logic [15:0]            q5_ff;
   logic signed [15:0]     f_in;
   logic signed [14:0]     c_o_ff;
   logic signed [15:0]     f_o_ff;

   logic signed [14:0]     skid_c_ff;
   logic signed [15:0]     skid_f_ff;
   logic                   skid_flt_ff;

   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_mv_ff    <= SUPPLY_MV_RST;
         step_uv_ff      <= STEP_UV_RST;
         series_ohms_ff  <= SERIES_OHMS_RST;
         nominal_ohms_ff <= NOMINAL_OHMS_RST;
         beta_kelvin_ff  <= BETA_KELVIN_RST;
         nominal_temp_ff <= NOMINAL_TEMP_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_SUPPLY_MV:    supply_mv_ff    <= csr_data[12:0];
            REG_STEP_UV:      step_uv_ff      <= csr_data[13:0];
            REG_SERIES_OHMS:  series_ohms_ff  <= csr_data;
            REG_NOMINAL_OHMS: nominal_ohms_ff <= csr_data;
            REG_BETA_KELVIN:  beta_kelvin_ff  <= csr_data[13:0];
            REG_NOMINAL_TEMP: nominal_temp_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // T0 is always positive, so its low 16 bits serve as unsigned
   always_ff @(posedge clock) begin
      t0_ff  <= {{2{nominal_temp_ff[14]}}, nominal_temp_ff} + $signed(KELVIN_CENTI);
      bs_ff  <= {19'(beta_kelvin_ff) * 19'd25, 18'b0};
      bt0_ff <= 30'(beta_kelvin_ff) * 30'(t0_ff[15:0]);
      num_ff <= {35'(bt0_ff) * 35'd25, 18'b0};
   end

   // flow control
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < DEPTH; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // front: voltage, supply, fault, divider products
   assign v_in     = V_W'(req_raw_code) * V_W'(step_uv_ff);
   assign sup_in   = SUP_W'(supply_mv_ff) * SUP_W'(1000);
   assign fault_in = czero_ff || (CMP_W'(v_ff) >= CMP_W'(sup_ff)) ||
                     (series_ohms_ff == '0) || (nominal_ohms_ff == '0) ||
                     (beta_kelvin_ff == '0);
   assign diff_in  = sup_ff - SUP_W'(v_ff);

   // log ratio magnitude and sign
   assign a_in    = (lnum < lden) ? (lden - lnum) : (lnum - lden);
   assign mag_rnd = mag_ff + (52'd1 << 29);
   assign lq_in   = neg_ff[1] ? -$signed({1'b0, mag_rnd[51:30]})
                              :  $signed({1'b0, mag_rnd[51:30]});
   assign den_in  = {prod_ff[39], prod_ff} + {4'b0, bs_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff      <= v_in;
         sup_ff    <= sup_in;
         czero_ff  <= (req_raw_code == '0);
         diff_ff   <= diff_in;
         v23_ff    <= SUP_W'(v_ff);
         rnum_ff   <= LOG_IN_W'(series_ohms_ff) * LOG_IN_W'(v23_ff);
         rden_ff   <= LOG_IN_W'(nominal_ohms_ff) * LOG_IN_W'(diff_ff);
         a_ff      <= a_in;
         neg_ff[0] <= (lnum < lden);
         neg_ff[1] <= neg_ff[0];
         mag_ff    <= 52'(a_ff) * 52'(LN2_Q30);
         lq_ff     <= lq_in;
         prod_ff   <= 40'(lq_ff * t0_ff);
         den_ff    <= den_in;
         dn_ff     <= DIV_N_W'(num_ff) + DIV_N_W'(den_ff[39:1]);
         dd_ff     <= den_ff[39:0];
         dpos_ff   <= !den_ff[40] && (den_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flt_ff[1] <= fault_in;
         for (int k = 2; k < DEPTH; k++) flt_ff[k] <= flt_ff[k-1];
      end
   end

   tbt_log2 u_log_num (
      .clock (clock),
      .en    (en),
      .x     (rnum_ff),
      .y     (lnum)
   );

   tbt_log2 u_log_den (
      .clock (clock),
      .en    (en),
      .x     (rden_ff),
      .y     (lden)
   );

   tbt_div u_div (
      .clock   (clock),
      .en      (en),
      .num     (dn_ff),
      .den     (dd_ff),
      .den_pos (dpos_ff),
      .quo     (tk)
   );

   // back: clamp kelvin, convert, round the fahrenheit fifth half away from zero
   always_comb begin
      priority if (tk < TK_MIN) tkc_in = TK_MIN;
      else if (tk > TK_MAX)     tkc_in = TK_MAX;
      else                      tkc_in = tk;
   end

   assign f9_in = 19'(c_a_ff) * 19'sd9;
   assign x_in  = f9_in[18] ? 18'(-f9_in) + 18'd2 : 18'(f9_in) + 18'd2;
   assign qp_in = 36'(x_ff) * 36'(RECIP5);
   assign f_in  = fneg_c_ff ? $signed(F_OFFSET - q5_ff) : $signed(F_OFFSET + q5_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         c_a_ff    <= 15'($signed({1'b0, tkc_in}) - $signed(KELVIN_CENTI));
         c_b_ff    <= c_a_ff;
         x_ff      <= x_in;
         fneg_b_ff <= f9_in[18];
         c_c_ff    <= c_b_ff;
         q5_ff     <= qp_in[35:20];
         fneg_c_ff <= fneg_b_ff;
         c_o_ff    <= flt_ff[LAST-1] ? '0 : c_c_ff;
         f_o_ff    <= flt_ff[LAST-1] ? '0 : f_in;
      end
   end

   // skid entry holds the last stage when the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (!rsp_stall) skid_v_ff <= 1'b0;
      end else if (vld_ff[LAST] && rsp_stall) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_c_ff   <= c_o_ff;
         skid_f_ff   <= f_o_ff;
         skid_flt_ff <= flt_ff[LAST];
      end
   end

   assign rsp_valid        = skid_v_ff || vld_ff[LAST];
   assign rsp_temp_c_centi = skid_v_ff ? skid_c_ff : c_o_ff;
   assign rsp_temp_f_centi = skid_v_ff ? skid_f_ff : f_o_ff;
   assign rsp_fault        = skid_v_ff ? skid_flt_ff : flt_ff[LAST];

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_temp_c_centi == '0 && rsp_temp_f_centi == '0)
      else $error("fault result with nonzero temperature");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fault |->
         rsp_temp_c_centi >= C_MIN && rsp_temp_c_centi <= C_MAX &&
         rsp_temp_f_centi >= F_MIN && rsp_temp_f_centi <= F_MAX)
      else $error("temperature outside saturation range");

   a_sat_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fault && rsp_temp_c_centi == C_MAX |-> rsp_temp_f_centi == F_MAX)
      else $error("celsius saturated high without fahrenheit");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(vld_ff[LAST] && rsp_stall))
      else $error("skid entry filled without a stalled result");

endmodule
